FILE: rtl/srld_pkg.sv
// Shared types and constants for the sprite run-length decoder.
`default_nettype none

package srld_pkg;

  localparam int SRLD_SPRITE_SIDE = 32;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index of the alpha mode register.
  localparam logic REG_HAS_ALPHA = 1'b0;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  typedef enum logic [2:0] {
    PH_TRANS_LO = 3'd0,
    PH_TRANS_HI = 3'd1,
    PH_COLOR_LO = 3'd2,
    PH_COLOR_HI = 3'd3,
    PH_PIXEL    = 3'd4,
    PH_IGNORE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [9:0]  pixel_index;
    logic [7:0]  color_byte_zero;
    logic [7:0]  color_byte_one;
    logic [7:0]  color_byte_two;
    logic [7:0]  alpha_byte;
    logic        sprite_done;
    logic [10:0] final_position;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/sprite_run_length_decoder.sv
// Sprite run-length decoder: input register, body parser and result register.
//
// Usage: body bytes of one square sprite enter on the input channel
// (in_valid / in_ready), one item per byte; byte_valid 0 gives an empty item.
// The item with last_byte ends the sprite and the parser starts over.
// Results leave on the output channel (out_valid / out_ready): one for each
// completed colored pixel, and one for the last item, which carries
// sprite_done and the final position (both may share a single result).
// An accepted item waits in the input register; the parser step writes any
// result to the result register once the output slot is free. One item per
// cycle is sustained while out_ready stays high. When the receiver stalls, a
// waiting result holds the output register and one more item can sit in the
// input register; in_ready then drops. has_alpha must be written through the
// APB port at byte address 0 only while no item is in flight; the block does
// not enforce this. Reset clears the parser, both pipeline registers and
// has_alpha; the block accepts items from the first cycle after reset.
`default_nettype none

module sprite_run_length_decoder
  import srld_pkg::*;
#(
  parameter int SPRITE_SIDE = SRLD_SPRITE_SIDE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               byte_valid,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    pixel_valid,
  output logic [9:0]              pixel_index,
  output logic [7:0]              color_byte_zero,
  output logic [7:0]              color_byte_one,
  output logic [7:0]              color_byte_two,
  output logic [7:0]              alpha_byte,
  output logic                    sprite_done,
  output logic [10:0]             final_position
);

  logic    has_alpha;
  logic    stage_valid;
  item_t   stage_item;
  logic    slot_free;
  logic    step;
  logic    produce;
  result_t step_result;
  result_t out_result;

  assign pready = 1'b1;

  srld_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .has_alpha (has_alpha)
  );

  assign slot_free = !out_valid || out_ready;
  assign step      = stage_valid && slot_free;
  assign in_ready  = !stage_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= '{byte_valid: byte_valid, data_byte: data_byte, last_byte: last_byte};
    end
  end

  srld_parser #(
    .SPRITE_SIDE (SPRITE_SIDE)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .has_alpha (has_alpha),
    .step      (step),
    .item      (stage_item),
    .produce   (produce),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= step && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_result <= step_result;
    end
  end

  assign pixel_valid     = out_result.pixel_valid;
  assign pixel_index     = out_result.pixel_index;
  assign color_byte_zero = out_result.color_byte_zero;
  assign color_byte_one  = out_result.color_byte_one;
  assign color_byte_two  = out_result.color_byte_two;
  assign alpha_byte      = out_result.alpha_byte;
  assign sprite_done     = out_result.sprite_done;
  assign final_position  = out_result.final_position;

`ifndef ASSERT_OFF
  // Every result carries a pixel write, an end of sprite, or both.
  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_valid || sprite_done))
    else $error("result carries neither a pixel nor a sprite end");

  // Without alpha, every written pixel is opaque.
  a_opaque_without_alpha: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_valid && !has_alpha) |-> (alpha_byte == OPAQUE_ALPHA))
    else $error("pixel without alpha is not opaque");

  // Pixel fields are zero on a result that only ends the sprite.
  a_zero_fields_without_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_valid) |->
      (pixel_index == 10'd0 && color_byte_zero == 8'd0 && alpha_byte == 8'd0))
    else $error("pixel fields set on a result without a pixel");

  // A waiting item in the input register is processed as soon as the output frees.
  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_valid && !(in_valid && in_ready)) |=> !stage_valid)
    else $error("input register did not drain into a free output slot");

  // Reset empties both pipeline registers.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !stage_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

FILE: rtl/srld_cfg_regs.sv
// Configuration register file with an APB-style access port.
`default_nettype none

module srld_cfg_regs
  import srld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    has_alpha
);

  logic reg_index;
  logic wr_en;

  // Registers sit on 32-bit word addresses; the low address bits are ignored.
  assign reg_index = paddr[PADDR_W-1];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_alpha <= 1'b0;
    end else if (wr_en && reg_index == REG_HAS_ALPHA) begin
      has_alpha <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_HAS_ALPHA) begin
      prdata = PDATA_W'(has_alpha);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srld_parser.sv
// Body parser state and the combinational step that handles one byte.
`default_nettype none

module srld_parser
  import srld_pkg::*;
#(
  parameter int SPRITE_SIDE = SRLD_SPRITE_SIDE
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    has_alpha,
  input  wire logic    step,
  input  wire item_t   item,
  output logic         produce,
  output result_t      result
);

  localparam int TOTAL_PIX = SPRITE_SIDE * SPRITE_SIDE;
  localparam int POS_W     = $clog2(TOTAL_PIX + 1);
  localparam int SUM_W     = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam logic [POS_W-1:0] TOTAL = POS_W'(TOTAL_PIX);

  phase_t            phase, phase_next;
  logic [7:0]        count_low_byte, count_low_byte_next;
  logic [15:0]       colored_left, colored_left_next;
  logic [POS_W-1:0]  write_position, write_position_next;
  logic [1:0]        pixel_byte_count, pixel_byte_count_next;
  logic [23:0]       pixel_bytes_held, pixel_bytes_held_next;

  logic [SUM_W-1:0]  skip_sum;
  logic [POS_W-1:0]  pos_plus;
  logic [15:0]       left_minus;
  logic              pixel_complete;

  assign skip_sum   = SUM_W'(write_position) + SUM_W'({item.data_byte, count_low_byte});
  assign pos_plus   = write_position + POS_W'(1);
  assign left_minus = colored_left - 16'd1;
  // Three bytes already held complete the pixel even when alpha has been turned off.
  assign pixel_complete = has_alpha ? (pixel_byte_count == 2'd3)
                                    : (pixel_byte_count >= 2'd2);

  always_comb begin
    phase_next            = phase;
    count_low_byte_next   = count_low_byte;
    colored_left_next     = colored_left;
    write_position_next   = write_position;
    pixel_byte_count_next = pixel_byte_count;
    pixel_bytes_held_next = pixel_bytes_held;
    result                = '0;
    produce               = 1'b0;

    if (step) begin
      if (item.byte_valid) begin
        case (phase)
          PH_TRANS_LO: begin
            count_low_byte_next = item.data_byte;
            phase_next          = PH_TRANS_HI;
          end
          PH_TRANS_HI: begin
            if (skip_sum >= SUM_W'(TOTAL)) begin
              write_position_next = TOTAL;
              phase_next          = PH_IGNORE;
            end else begin
              write_position_next = POS_W'(skip_sum);
              phase_next          = PH_COLOR_LO;
            end
          end
          PH_COLOR_LO: begin
            count_low_byte_next = item.data_byte;
            phase_next          = PH_COLOR_HI;
          end
          PH_COLOR_HI: begin
            colored_left_next     = {item.data_byte, count_low_byte};
            pixel_byte_count_next = 2'd0;
            pixel_bytes_held_next = '0;
            phase_next = ({item.data_byte, count_low_byte} == 16'd0) ? PH_TRANS_LO
                                                                      : PH_PIXEL;
          end
          PH_PIXEL: begin
            if (pixel_complete) begin
              result.pixel_valid     = 1'b1;
              result.pixel_index     = 10'(write_position);
              result.color_byte_zero = pixel_bytes_held[7:0];
              result.color_byte_one  = pixel_bytes_held[15:8];
              if (has_alpha) begin
                result.color_byte_two = pixel_bytes_held[23:16];
                result.alpha_byte     = item.data_byte;
              end else if (pixel_byte_count == 2'd3) begin
                result.color_byte_two = pixel_bytes_held[23:16];
                result.alpha_byte     = OPAQUE_ALPHA;
              end else begin
                result.color_byte_two = item.data_byte;
                result.alpha_byte     = OPAQUE_ALPHA;
              end
              write_position_next   = pos_plus;
              colored_left_next     = left_minus;
              pixel_byte_count_next = 2'd0;
              pixel_bytes_held_next = '0;
              if (pos_plus >= TOTAL) begin
                phase_next = PH_IGNORE;
              end else if (left_minus == 16'd0) begin
                phase_next = PH_TRANS_LO;
              end
            end else begin
              case (pixel_byte_count)
                2'd0:    pixel_bytes_held_next[7:0]   = item.data_byte;
                2'd1:    pixel_bytes_held_next[15:8]  = item.data_byte;
                2'd2:    pixel_bytes_held_next[23:16] = item.data_byte;
                default: pixel_bytes_held_next        = pixel_bytes_held;
              endcase
              pixel_byte_count_next = pixel_byte_count + 2'd1;
            end
          end
          default: begin
            phase_next = PH_IGNORE;
          end
        endcase
      end

      produce = result.pixel_valid || item.last_byte;

      if (item.last_byte) begin
        result.sprite_done    = 1'b1;
        result.final_position = 11'(write_position_next);
        phase_next            = PH_TRANS_LO;
        count_low_byte_next   = '0;
        colored_left_next     = '0;
        write_position_next   = '0;
        pixel_byte_count_next = '0;
        pixel_bytes_held_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TRANS_LO;
      count_low_byte   <= '0;
      colored_left     <= '0;
      write_position   <= '0;
      pixel_byte_count <= '0;
      pixel_bytes_held <= '0;
    end else begin
      phase            <= phase_next;
      count_low_byte   <= count_low_byte_next;
      colored_left     <= colored_left_next;
      write_position   <= write_position_next;
      pixel_byte_count <= pixel_byte_count_next;
      pixel_bytes_held <= pixel_bytes_held_next;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Sprite run-length decoder testbench: directed and random sprite bodies checked by an in-bench decoder.
`timescale 1ns / 100ps

module tb
  import srld_pkg::*;
();

  localparam int PIXEL_TOTAL = SRLD_SPRITE_SIDE * SRLD_SPRITE_SIDE;
  localparam int MAX_REPORTS = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               byte_valid = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               pixel_valid;
  logic [9:0]         pixel_index;
  logic [7:0]         color_byte_zero;
  logic [7:0]         color_byte_one;
  logic [7:0]         color_byte_two;
  logic [7:0]         alpha_byte;
  logic               sprite_done;
  logic [10:0]        final_position;

  sprite_run_length_decoder uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Decoder state mirrored by the bench.
  phase_t      dec_phase;
  logic [7:0]  run_lo;
  logic [15:0] colored_left;
  int          write_pos;
  int          held_cnt;
  logic [23:0] held_bytes;
  bit          alpha_mode;

  item_t   byte_queue[$];
  result_t decoded_queue[$];
  int      error_count = 0;
  int      valid_bytes_sent = 0;
  int      send_gap;
  int      recv_stall;
  bit      send_idle = 1'b0;
  bit      recv_idle = 1'b1;

  function automatic void clear_decoder();
    dec_phase    = PH_TRANS_LO;
    run_lo       = 8'h00;
    colored_left = 16'h0000;
    write_pos    = 0;
    held_cnt     = 0;
    held_bytes   = 24'h0;
  endfunction

  // Applies one item to the mirrored state; returns 1 when the item yields a result.
  function automatic bit decode_byte(input item_t it, output result_t res);
    bit wrote;
    wrote = 1'b0;
    res   = '0;
    if (it.byte_valid) begin
      case (dec_phase)
        PH_TRANS_LO: begin
          run_lo    = it.data_byte;
          dec_phase = PH_TRANS_HI;
        end
        PH_TRANS_HI: begin
          write_pos = write_pos + int'({it.data_byte, run_lo});
          if (write_pos >= PIXEL_TOTAL) begin
            write_pos = PIXEL_TOTAL;
            dec_phase = PH_IGNORE;
          end else begin
            dec_phase = PH_COLOR_LO;
          end
        end
        PH_COLOR_LO: begin
          run_lo    = it.data_byte;
          dec_phase = PH_COLOR_HI;
        end
        PH_COLOR_HI: begin
          colored_left = {it.data_byte, run_lo};
          held_cnt     = 0;
          held_bytes   = 24'h0;
          dec_phase    = (colored_left == 16'h0000) ? PH_TRANS_LO : PH_PIXEL;
        end
        PH_PIXEL: begin
          if (held_cnt + 1 >= (alpha_mode ? 4 : 3)) begin
            res.pixel_valid     = 1'b1;
            res.pixel_index     = write_pos[9:0];
            res.color_byte_zero = held_bytes[7:0];
            res.color_byte_one  = held_bytes[15:8];
            if (alpha_mode) begin
              res.color_byte_two = held_bytes[23:16];
              res.alpha_byte     = it.data_byte;
            end else if (held_cnt >= 3) begin
              // Alpha was turned off with three bytes held: this byte is dropped.
              res.color_byte_two = held_bytes[23:16];
              res.alpha_byte     = OPAQUE_ALPHA;
            end else begin
              res.color_byte_two = it.data_byte;
              res.alpha_byte     = OPAQUE_ALPHA;
            end
            wrote        = 1'b1;
            write_pos    = write_pos + 1;
            colored_left = colored_left - 16'd1;
            held_cnt     = 0;
            held_bytes   = 24'h0;
            if (write_pos >= PIXEL_TOTAL) begin
              dec_phase = PH_IGNORE;
            end else if (colored_left == 16'h0000) begin
              dec_phase = PH_TRANS_LO;
            end
          end else begin
            held_bytes[8*held_cnt +: 8] = it.data_byte;
            held_cnt = held_cnt + 1;
          end
        end
        default: begin
          dec_phase = PH_IGNORE;
        end
      endcase
    end
    if (it.last_byte) begin
      res.sprite_done    = 1'b1;
      res.final_position = write_pos[10:0];
      clear_decoder();
    end
    return wrote || it.last_byte;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("pix=%0b idx=%0d color=%02h/%02h/%02h alpha=%02h done=%0b pos=%0d",
                     r.pixel_valid, r.pixel_index, r.color_byte_zero, r.color_byte_one,
                     r.color_byte_two, r.alpha_byte, r.sprite_done, r.final_position);
  endfunction

  // Mostly no gap, some short ones and an occasional long one.
  function automatic int pick_gap(bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  always @(posedge clk) begin : item_driver
    item_t   cur;
    result_t want;
    if (rst) begin
      in_valid   <= 1'b0;
      send_gap   = 0;
      alpha_mode = 1'b0;
      clear_decoder();
    end else begin
      if (in_valid && in_ready) begin
        cur = '{byte_valid, data_byte, last_byte};
        if (decode_byte(cur, want)) decoded_queue = {decoded_queue, want};
      end
      // A waiting item keeps valid and payload until it is taken.
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          cur = byte_queue[0];
          byte_queue.delete(0);
          byte_valid <= cur.byte_valid;
          data_byte  <= cur.data_byte;
          last_byte  <= cur.last_byte;
          in_valid   <= 1'b1;
          send_gap   = pick_gap(send_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_receiver
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      recv_stall = pick_gap(recv_idle);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{pixel_valid, pixel_index, color_byte_zero, color_byte_one, color_byte_two,
              alpha_byte, sprite_done, final_position};
      if (decoded_queue.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS) $display("unexpected result: %s", show(got));
      end else begin
        want = decoded_queue[0];
        decoded_queue.delete(0);
        if (got.pixel_valid !== want.pixel_valid || got.pixel_index !== want.pixel_index ||
            got.color_byte_zero !== want.color_byte_zero ||
            got.color_byte_one !== want.color_byte_one ||
            got.color_byte_two !== want.color_byte_two ||
            got.alpha_byte !== want.alpha_byte || got.sprite_done !== want.sprite_done ||
            got.final_position !== want.final_position) begin
          error_count = error_count + 1;
          if (error_count <= MAX_REPORTS) begin
            $display("result mismatch: expected %s", show(want));
            $display("                 got      %s", show(got));
          end
        end
      end
    end
  end

  task automatic push_item(bit bv, logic [7:0] b, bit last);
    item_t it;
    it = '{bv, b, last};
    byte_queue = {byte_queue, it};
    if (bv) valid_bytes_sent = valid_bytes_sent + 1;
  endtask

  // Holds the sender until every item has left the block, then lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || decoded_queue.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_alpha(bit value);
    wait_drained();
    paddr   <= PADDR_W'(4 * int'(REG_HAS_ALPHA));
    pwdata  <= PDATA_W'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alpha_mode = value;
    @(negedge clk);
  endtask

  task automatic gen_sprite();
    logic [7:0]  body[$];
    logic [15:0] run_len;
    int          pick;
    int          npix;
    int          cut;
    int          switch_at;
    bit          empty_end;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 30)) body = {body, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) run_len = 16'($urandom_range(0, 40));
        else if (pick < 85) run_len = 16'($urandom_range(990, 1030));
        else run_len = 16'($urandom);
        body = {body, run_len[7:0]};
        body = {body, run_len[15:8]};
        pick = $urandom_range(0, 99);
        if (pick < 50) run_len = 16'($urandom_range(1, 4));
        else if (pick < 70) run_len = 16'h0000;
        else if (pick < 90) run_len = 16'($urandom_range(5, 12));
        else run_len = 16'($urandom);
        body = {body, run_len[7:0]};
        body = {body, run_len[15:8]};
        npix = (run_len < 16'd13) ? int'(run_len) : $urandom_range(0, 12);
        repeat (npix * (alpha_mode ? 4 : 3)) body = {body, 8'($urandom)};
      end
    end
    pick      = $urandom_range(0, 99);
    cut       = body.size();
    // Some bodies end early, in a count or in a pixel; some end on an empty item.
    if (pick < 15 && cut > 1) cut = $urandom_range(1, cut - 1);
    empty_end = (pick >= 15 && pick < 30);
    switch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cut - 1) : -1;
    for (int k = 0; k < cut; k++) begin
      if (k == switch_at) set_alpha(!alpha_mode);
      if ($urandom_range(0, 9) == 0) push_item(1'b0, 8'($urandom), 1'b0);
      push_item(1'b1, body[k], !empty_end && k == cut - 1);
    end
    if (empty_end) push_item(1'b0, 8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    @(negedge clk);
    while (rst) @(negedge clk);

    // An empty item that ends a sprite at once.
    push_item(1'b0, 8'h5A, 1'b1);
    // One opaque pixel at index zero, an empty colored run, then a transparent
    // run that overflows the sprite; the bytes after it are ignored.
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h01, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'hFF, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h80, 1'b0);
    push_item(1'b1, 8'h05, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'hFF, 1'b0);
    push_item(1'b1, 8'hFF, 1'b0);
    push_item(1'b1, 8'hAB, 1'b0);
    push_item(1'b0, 8'h00, 1'b0);
    push_item(1'b1, 8'hFF, 1'b1);

    // With alpha on: fill the last two pixels by writes, turning alpha off
    // while the final pixel holds three bytes.
    set_alpha(1'b1);
    push_item(1'b1, 8'hFE, 1'b0);
    push_item(1'b1, 8'h03, 1'b0);
    push_item(1'b1, 8'h03, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h10, 1'b0);
    push_item(1'b1, 8'h20, 1'b0);
    push_item(1'b1, 8'h30, 1'b0);
    push_item(1'b1, 8'h00, 1'b0);
    push_item(1'b1, 8'h01, 1'b0);
    push_item(1'b1, 8'h02, 1'b0);
    push_item(1'b1, 8'h03, 1'b0);
    set_alpha(1'b0);
    push_item(1'b1, 8'h04, 1'b0);
    push_item(1'b0, 8'hC3, 1'b1);

    while (valid_bytes_sent < 430) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) set_alpha(1'($urandom_range(0, 1)));
      gen_sprite();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
